// ===== hdl/fbe_pkg.sv =====
// Shared types, constants and helper functions for the feature bitset engine.
// No dependencies; the engine, the top level and the checker import this package.
package fbe_pkg;

    localparam int MAX_FEATURES = 64;
    localparam int IDX_W        = 6;
    localparam int CNT_W        = 7;
    localparam int KIND_W       = 3;
    localparam int HASH_W       = 64;
    localparam int WORD_W       = 8;
    localparam int BIT_W        = 3;
    localparam int WORD_NUM     = MAX_FEATURES / WORD_W;
    localparam int WADDR_W      = IDX_W - BIT_W;

    localparam logic [CNT_W-1:0]  FC_RESET  = 7'd64;
    localparam logic [HASH_W-1:0] HASH_SEED = 64'd1469598103934665603;
    localparam logic [HASH_W-1:0] HASH_GOLD = 64'h9e37_79b9_7f4a_7c15;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD      = 3'd0,
        KIND_REMOVE   = 3'd1,
        KIND_CONTAINS = 3'd2,
        KIND_LIST     = 3'd3,
        KIND_HASH     = 3'd4,
        KIND_CLEAR    = 3'd5
    } kind_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [IDX_W-1:0]  feature_index;
    } in_item_t;

    typedef struct packed {
        logic              flag;
        logic [CNT_W-1:0]  member_count;
        logic [IDX_W-1:0]  member_index;
        logic              member_valid;
        logic [HASH_W-1:0] hash_value;
        logic              error;
        logic              last;
    } out_item_t;

    // Result request from the engine to the output register
    typedef struct packed {
        logic      vld;
        out_item_t item;
    } push_t;

    function automatic logic [HASH_W-1:0] hash_mix(input logic [HASH_W-1:0] seed,
                                                   input logic [HASH_W-1:0] v);
        return seed ^ (v + HASH_GOLD + (seed << 6) + (seed >> 2));
    endfunction

    // Position of the lowest set bit of a word (0 when the word is empty)
    function automatic logic [BIT_W-1:0] lowest_bit(input logic [WORD_W-1:0] w);
        logic [BIT_W-1:0] pos;
        pos = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (w[i])
            begin
                pos = BIT_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

// ===== hdl/fbe_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module fbe_ram #(
    parameter int DEPTH  = 8,
    parameter int WIDTH  = 8,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hdl/fbe_engine.sv =====
// Command sequencer: read-modify-write of bitset words, list scan and hash fold.
// Depends on fbe_pkg and fbe_ram (the member word memory).
module fbe_engine (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  fbe_pkg::in_item_t       in_data,
    input  logic [fbe_pkg::CNT_W-1:0] feature_count,
    output fbe_pkg::push_t          push,
    input  logic                    push_ok
);
    import fbe_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_RMW     = 7'b0000010,
        S_HTOT    = 7'b0000100,
        S_SCAN_RD = 7'b0001000,
        S_SCAN_LD = 7'b0010000,
        S_STEP    = 7'b0100000,
        S_ONE     = 7'b1000000
    } state_t;

    state_t              state_reg, state_next;
    logic [KIND_W-1:0]   kind_reg, kind_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    total_reg, total_next;
    logic [CNT_W-1:0]    emit_reg, emit_next;
    logic [WADDR_W-1:0]  waddr_reg, waddr_next;
    logic [WORD_W-1:0]   word_reg, word_next;
    logic [HASH_W-1:0]   seed_reg, seed_next;
    logic [WORD_NUM-1:0] wvld_reg, wvld_next;
    logic                rd_vld_reg;

    logic                rd_en;
    logic [WADDR_W-1:0]  rd_addr;
    logic [WORD_W-1:0]   rd_data;
    logic                wr_en;
    logic [WORD_W-1:0]   wr_data;

    logic                accept;
    logic [WORD_W-1:0]   ram_word;
    logic                present;
    logic                bad;
    logic [BIT_W-1:0]    low_pos;
    logic [IDX_W-1:0]    member;
    logic                last_member;

    fbe_ram #(
        .DEPTH (WORD_NUM),
        .WIDTH (WORD_W)
    ) u_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (idx_reg[IDX_W-1:BIT_W]),
        .wr_data (wr_data)
    );

    assign in_stall    = (state_reg != S_IDLE);
    assign accept      = in_valid && (state_reg == S_IDLE);
    // Unwritten words since the last clear read as empty
    assign ram_word    = rd_vld_reg ? rd_data : '0;
    assign present     = ram_word[idx_reg[BIT_W-1:0]];
    assign bad         = ({1'b0, idx_reg} >= feature_count);
    assign low_pos     = lowest_bit(word_reg);
    assign member      = {waddr_reg, low_pos};
    assign last_member = ((emit_reg + CNT_W'(1)) == total_reg);

    always_comb
    begin
        rd_en = 1'b0;
        rd_addr = waddr_reg;
        if (accept)
        begin
            rd_en = 1'b1;
            rd_addr = in_data.feature_index[IDX_W-1:BIT_W];
        end
        else if (state_reg == S_SCAN_RD)
        begin
            rd_en = 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        idx_next   = idx_reg;
        total_next = total_reg;
        emit_next  = emit_reg;
        waddr_next = waddr_reg;
        word_next  = word_reg;
        seed_next  = seed_reg;
        wvld_next  = wvld_reg;
        wr_en      = 1'b0;
        wr_data    = ram_word;
        push       = '0;
        push.item.member_count = total_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    kind_next = in_data.kind;
                    idx_next  = in_data.feature_index;
                    waddr_next = '0;
                    emit_next  = '0;
                    case (in_data.kind)
                        KIND_ADD, KIND_REMOVE, KIND_CONTAINS:
                        begin
                            state_next = S_RMW;
                        end
                        KIND_LIST:
                        begin
                            state_next = (total_reg == '0) ? S_ONE : S_SCAN_RD;
                        end
                        KIND_HASH:
                        begin
                            seed_next  = hash_mix(HASH_SEED, HASH_W'(feature_count));
                            state_next = S_HTOT;
                        end
                        KIND_CLEAR:
                        begin
                            wvld_next  = '0;
                            total_next = '0;
                            state_next = S_ONE;
                        end
                        default:
                        begin
                            // drop unknown commands
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_RMW:
            begin
                push.vld        = 1'b1;
                push.item.last  = 1'b1;
                push.item.error = bad;
                if (!bad)
                begin
                    case (kind_reg)
                        KIND_ADD:
                        begin
                            push.item.flag = !present;
                            if (!present)
                            begin
                                total_next = total_reg + CNT_W'(1);
                                wr_data = ram_word | (WORD_W'(1) << idx_reg[BIT_W-1:0]);
                            end
                        end
                        KIND_REMOVE:
                        begin
                            push.item.flag = present;
                            if (present)
                            begin
                                total_next = total_reg - CNT_W'(1);
                                wr_data = ram_word & ~(WORD_W'(1) << idx_reg[BIT_W-1:0]);
                            end
                        end
                        default:
                        begin
                            push.item.flag = present;
                        end
                    endcase
                end
                push.item.member_count = total_next;
                if (push_ok)
                begin
                    if (!bad && (kind_reg inside {KIND_ADD, KIND_REMOVE}))
                    begin
                        wr_en = 1'b1;
                        wvld_next[idx_reg[IDX_W-1:BIT_W]] = 1'b1;
                    end
                    state_next = S_IDLE;
                end
                else
                begin
                    total_next = total_reg;
                end
            end

            S_HTOT:
            begin
                seed_next  = hash_mix(seed_reg, HASH_W'(total_reg));
                state_next = (total_reg == '0) ? S_ONE : S_SCAN_RD;
            end

            S_SCAN_RD:
            begin
                state_next = S_SCAN_LD;
            end

            S_SCAN_LD:
            begin
                word_next  = ram_word;
                state_next = S_STEP;
            end

            S_STEP:
            begin
                if (word_reg == '0)
                begin
                    waddr_next = waddr_reg + WADDR_W'(1);
                    state_next = S_SCAN_RD;
                end
                else if (kind_reg == KIND_HASH)
                begin
                    seed_next = hash_mix(seed_reg, HASH_W'(member));
                    word_next = word_reg & ~(WORD_W'(1) << low_pos);
                    emit_next = emit_reg + CNT_W'(1);
                    if (last_member)
                    begin
                        state_next = S_ONE;
                    end
                end
                else
                begin
                    push.vld               = 1'b1;
                    push.item.member_index = member;
                    push.item.member_valid = 1'b1;
                    push.item.last         = last_member;
                    if (push_ok)
                    begin
                        word_next = word_reg & ~(WORD_W'(1) << low_pos);
                        emit_next = emit_reg + CNT_W'(1);
                        if (last_member)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
            end

            S_ONE:
            begin
                push.vld       = 1'b1;
                push.item.last = 1'b1;
                if (kind_reg == KIND_HASH)
                begin
                    push.item.hash_value = seed_reg;
                end
                if (push_ok)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            total_reg  <= '0;
            wvld_reg   <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            total_reg <= total_next;
            wvld_reg  <= wvld_next;
            if (rd_en)
            begin
                rd_vld_reg <= wvld_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        idx_reg   <= idx_next;
        emit_reg  <= emit_next;
        waddr_reg <= waddr_next;
        word_reg  <= word_next;
        seed_reg  <= seed_next;
    end

endmodule

// ===== hdl/feature_bitset_engine.sv =====
// Top level of the feature bitset engine: config register, engine, output register.
// Depends on fbe_pkg, fbe_engine and fbe_ram.
//
// The block keeps a set of up to 64 feature indices in an 8 x 8-bit word memory
// plus a running member count. One request is worked at a time. Add, remove and
// contains are accepted, then do a read-modify-write of one word; clear is
// accepted, then gives its one result. A list scans the words up to and including
// the one holding the highest member: each costs a memory read, a load and a step
// that moves past it (the last word needs no such step), and each member one step
// of the scan. A hash mixes in the feature count at accept, then the member count,
// then scans the same way with one 64-bit combine step per member. An empty list
// gives one result marked invalid; an empty hash gives only its hash. Output stalls
// hold the steps that give results. Results go through an output register, so the
// next request is taken while a finished result still waits downstream. The feature
// count register is written through cfg_valid/cfg_ready; the user writes it only
// while the block is idle, and the block itself does not enforce this. Its reset
// value is 64 and it is mixed into the hash as written.
module feature_bitset_engine (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  fbe_pkg::in_item_t         in_data,
    output logic                      out_valid,
    input  logic                      out_stall,
    output fbe_pkg::out_item_t        out_data,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [fbe_pkg::CNT_W-1:0] cfg_data
);
    import fbe_pkg::*;

    logic [CNT_W-1:0] fc_reg;
    logic             out_valid_reg;
    out_item_t        out_reg;
    push_t            push;
    logic             push_ok;

    // Config writes are always taken; the user writes only while idle
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fc_reg <= FC_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            fc_reg <= cfg_data;
        end
    end

    fbe_engine u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_data       (in_data),
        .feature_count (fc_reg),
        .push          (push),
        .push_ok       (push_ok)
    );

    // Output slot is free when empty or when its result leaves this cycle
    assign push_ok = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (push.vld && push_ok)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Hold the result while stalled, load a new one when the slot frees
    always_ff @(posedge clk)
    begin
        if (push.vld && push_ok)
        begin
            out_reg <= push.item;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== hdl/fbe_checker.sv =====
// Port-level checks of the feature bitset engine, bound to the top level.
// Depends on fbe_pkg and feature_bitset_engine.
module fbe_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      out_valid,
    input logic                      out_stall,
    input fbe_pkg::out_item_t        out_data
);
    import fbe_pkg::*;

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // An index error stands alone: no flag, no member, final result
    a_err_alone: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.error |->
            !out_data.flag && !out_data.member_valid && out_data.last)
        else $error("error result carries other fields");

    // A listed member never comes with a hash, error or flag
    a_member_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.member_valid |->
            out_data.hash_value == '0 && !out_data.error && !out_data.flag)
        else $error("member result carries hash or error");

    // Member count never exceeds the set capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.member_count <= CNT_W'(MAX_FEATURES))
        else $error("member count out of range");

endmodule

bind feature_bitset_engine fbe_checker u_fbe_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
